>>> hw/rtl/led_region_compositor_serializer_top_defines.svh
// Assertion macros for the LED region compositor checker.
// Depends on clk_i and rst_ni being visible where the macros are used.
`ifndef LED_REGION_COMPOSITOR_SERIALIZER_TOP_DEFINES_SVH
`define LED_REGION_COMPOSITOR_SERIALIZER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off while in reset.
`define LRC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off while in reset.
`define LRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/lrc_pkg.sv
// Shared types, codes and helper functions of the LED region compositor.
// No dependencies; used by every RTL module of the block.
package lrc_pkg;

  localparam int unsigned RegionSlotsDef = 16;
  localparam int unsigned SymbolCount    = 24;
  localparam int unsigned SymW           = 5;
  localparam logic [3:0]  AnyCoord       = 4'd8;

  localparam logic [7:0] OneHighRst  = 8'd58;
  localparam logic [7:0] OneLowRst   = 8'd20;
  localparam logic [7:0] ZeroHighRst = 8'd10;
  localparam logic [7:0] ZeroLowRst  = 8'd58;

  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_QUERY = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    STAT_SYMBOL  = 2'd0,
    STAT_STORED  = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_CLEARED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_ONE_HIGH  = 2'd0,
    CFG_ONE_LOW   = 2'd1,
    CFG_ZERO_HIGH = 2'd2,
    CFG_ZERO_LOW  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_HAND
  } state_e;

  typedef struct packed {
    logic [3:0] sx;
    logic [3:0] sy;
    logic [3:0] ex;
    logic [3:0] ey;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] blue;
  } region_t;

  typedef struct packed {
    logic [7:0] one_high;
    logic [7:0] one_low;
    logic [7:0] zero_high;
    logic [7:0] zero_low;
  } cfg_t;

  // One pending result handed from the control to the output stage.
  typedef struct packed {
    status_e     status;
    logic [23:0] word;
    logic        hit;
    logic [3:0]  row;
  } load_t;

  function automatic logic covers(region_t rg, logic [3:0] x, logic [3:0] y);
    logic row_ok;
    logic col_ok;
    row_ok = ((y >= rg.sy) && (y <= rg.ey)) || (rg.sy == AnyCoord);
    col_ok = ((x >= rg.sx) && (x <= rg.ex)) || (rg.sx == AnyCoord);
    return row_ok && col_ok;
  endfunction

endpackage

>>> hw/rtl/lrc_region_mem.sv
// Region table storage: one write port, one read port with registered data.
// Depends on lrc_pkg for the region entry type.
module lrc_region_mem import lrc_pkg::*; #(
  parameter int unsigned Depth = RegionSlotsDef,
  parameter int unsigned IdxW  = 4
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  region_t         wdata_i,
  input  logic            re_i,
  input  logic [IdxW-1:0] raddr_i,
  output region_t         rdata_o
);

  region_t mem_q [Depth];
  region_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/lrc_serializer.sv
// Output stage: holds the current result and shifts a color word out as
// 24 bit symbols, most significant bit first. Depends on lrc_pkg.
module lrc_serializer import lrc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       load_valid_i,
  output logic       load_ready_o,
  input  load_t      load_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] status_o,
  output logic       bit_value_o,
  output logic [7:0] high_time_o,
  output logic [7:0] low_time_o,
  output logic [3:0] row_o,
  output logic       region_hit_o,
  output logic       last_o
);

  logic            valid_q, valid_d;
  logic            last_q, last_d;
  status_e         status_q, status_d;
  logic            bit_q, bit_d;
  logic [3:0]      row_q, row_d;
  logic            hit_q, hit_d;
  logic [22:0]     shreg_q, shreg_d;
  logic [SymW-1:0] sym_q, sym_d;
  logic            fire;
  logic            is_sym;

  assign fire         = valid_q && out_ready_i;
  assign load_ready_o = !valid_q || (out_ready_i && last_q);

  always_comb begin
    valid_d  = valid_q;
    last_d   = last_q;
    status_d = status_q;
    bit_d    = bit_q;
    row_d    = row_q;
    hit_d    = hit_q;
    shreg_d  = shreg_q;
    sym_d    = sym_q;
    if (fire && !last_q) begin
      bit_d   = shreg_q[22];
      shreg_d = {shreg_q[21:0], 1'b0};
      sym_d   = sym_q + 1'b1;
      last_d  = (sym_q + 1'b1) == SymW'(SymbolCount - 1);
    end else if (load_valid_i && load_ready_o) begin
      valid_d  = 1'b1;
      status_d = load_i.status;
      sym_d    = '0;
      if (load_i.status == STAT_SYMBOL) begin
        bit_d   = load_i.word[23];
        shreg_d = load_i.word[22:0];
        row_d   = load_i.row;
        hit_d   = load_i.hit;
        last_d  = 1'b0;
      end else begin
        bit_d   = 1'b0;
        shreg_d = '0;
        row_d   = '0;
        hit_d   = 1'b0;
        last_d  = 1'b1;
      end
    end else if (fire) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      last_q  <= 1'b0;
      sym_q   <= '0;
    end else begin
      valid_q <= valid_d;
      last_q  <= last_d;
      sym_q   <= sym_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    bit_q    <= bit_d;
    row_q    <= row_d;
    hit_q    <= hit_d;
    shreg_q  <= shreg_d;
  end

  // Live durations; the user must change them only while idle (not enforced).
  assign is_sym       = (status_q == STAT_SYMBOL);
  assign out_valid_o  = valid_q;
  assign status_o     = status_q;
  assign bit_value_o  = bit_q;
  assign high_time_o  = !is_sym ? 8'd0 : (bit_q ? cfg_i.one_high : cfg_i.zero_high);
  assign low_time_o   = !is_sym ? 8'd0 : (bit_q ? cfg_i.one_low : cfg_i.zero_low);
  assign row_o        = row_q;
  assign region_hit_o = hit_q;
  assign last_o       = last_q;

endmodule

>>> hw/rtl/led_region_compositor_serializer_top.sv
// Top level of the LED region compositor and bit-symbol serializer.
// Depends on lrc_pkg, lrc_region_mem and lrc_serializer.
//
// Usage: requests arrive on the in_* channel and results leave on the out_*
// channel, both valid/ready; a transfer happens on a clock edge with valid
// and ready high. Configuration registers (line durations) are written
// through cfg_we_i/cfg_idx_i/cfg_wdata_i and take effect at once.
// An add request stores a region in the table memory and answers with one
// result (stored, or table full once REGION_SLOTS regions are held). A clear
// request empties the table and answers with one result. A query reads the
// table one entry per cycle in insertion order, stopping at the first region
// covering the pixel, then sends 24 bit symbols, green, red, blue, MSB first.
// Flow: an add or clear result is registered as the pending result and moves
// to the output register, raising out_valid_o, once that register is free. A
// query first reads N entries (zero on an empty table, at most REGION_SLOTS)
// and hands on its result alike; symbols go out one per cycle unless stalled.
// The next request is taken once the previous result is handed to the output
// register, so a new table scan overlaps with symbols still going out.
// Reset empties the table and loads the default durations. When the receiver
// stalls, the output holds its result and the block stops at the hand-off.
module led_region_compositor_serializer_top import lrc_pkg::*; #(
  parameter int unsigned REGION_SLOTS = RegionSlotsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] req_type_i,
  input  logic [3:0] start_x_i,
  input  logic [3:0] start_y_i,
  input  logic [3:0] end_x_i,
  input  logic [3:0] end_y_i,
  input  logic [7:0] green_i,
  input  logic [7:0] red_i,
  input  logic [7:0] blue_i,
  input  logic [3:0] pixel_x_i,
  input  logic [3:0] pixel_y_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] status_o,
  output logic       bit_value_o,
  output logic [7:0] high_time_o,
  output logic [7:0] low_time_o,
  output logic [3:0] row_o,
  output logic       region_hit_o,
  output logic       last_o
);

  localparam int unsigned CntW = $clog2(REGION_SLOTS + 1);
  localparam int unsigned IdxW = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{one_high: OneHighRst, one_low: OneLowRst,
                 zero_high: ZeroHighRst, zero_low: ZeroLowRst};
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ONE_HIGH:  cfg_q.one_high  <= cfg_wdata_i;
        CFG_ONE_LOW:   cfg_q.one_low   <= cfg_wdata_i;
        CFG_ZERO_HIGH: cfg_q.zero_high <= cfg_wdata_i;
        CFG_ZERO_LOW:  cfg_q.zero_low  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  state_e          state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] chk_q, chk_d;
  logic [CntW-1:0] chk_nxt;
  logic [3:0]      px_q, px_d;
  logic [3:0]      py_q, py_d;
  load_t           pend_q, pend_d;

  logic            mem_we;
  logic            mem_re;
  logic [IdxW-1:0] mem_raddr;
  region_t         mem_wdata;
  region_t         mem_rdata;
  logic            load_ready;
  logic            accept;

  assign accept    = in_valid_i && in_ready_o;
  assign chk_nxt   = chk_q + 1'b1;
  assign mem_wdata = '{sx: start_x_i, sy: start_y_i, ex: end_x_i, ey: end_y_i,
                       green: green_i, red: red_i, blue: blue_i};

  // The FSM serializes table accesses: writes happen only on an idle add, reads
  // only on a query start or its scan, so no entry is read and written together.
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    chk_d      = chk_q;
    px_d       = px_q;
    py_d       = py_q;
    pend_d     = pend_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          pend_d = '{status: STAT_SYMBOL, word: '0, hit: 1'b0, row: '0};
          case (req_e'(req_type_i))
            REQ_ADD: begin
              if (count_q < CntW'(REGION_SLOTS)) begin
                mem_we        = 1'b1;
                count_d       = count_q + 1'b1;
                pend_d.status = STAT_STORED;
              end else begin
                pend_d.status = STAT_FULL;
              end
              state_d = S_HAND;
            end
            REQ_CLEAR: begin
              count_d       = '0;
              pend_d.status = STAT_CLEARED;
              state_d       = S_HAND;
            end
            REQ_QUERY: begin
              px_d       = pixel_x_i;
              py_d       = pixel_y_i;
              pend_d.row = pixel_y_i;
              chk_d      = '0;
              if (count_q == '0) begin
                state_d = S_HAND;
              end else begin
                mem_re  = 1'b1;
                state_d = S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        // Read data belongs to entry chk_q; prefetch the next entry meanwhile.
        mem_re    = 1'b1;
        mem_raddr = chk_nxt[IdxW-1:0];
        if (covers(mem_rdata, px_q, py_q)) begin
          pend_d.word = {mem_rdata.green, mem_rdata.red, mem_rdata.blue};
          pend_d.hit  = 1'b1;
          state_d     = S_HAND;
        end else if (chk_nxt == count_q) begin
          state_d = S_HAND;
        end else begin
          chk_d = chk_nxt;
        end
      end
      S_HAND: begin
        if (load_ready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      chk_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      chk_q   <= chk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q   <= px_d;
    py_q   <= py_d;
    pend_q <= pend_d;
  end

  lrc_region_mem #(
    .Depth (REGION_SLOTS),
    .IdxW  (IdxW)
  ) u_region_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  lrc_serializer u_serializer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .load_valid_i (state_q == S_HAND),
    .load_ready_o (load_ready),
    .load_i       (pend_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .bit_value_o  (bit_value_o),
    .high_time_o  (high_time_o),
    .low_time_o   (low_time_o),
    .row_o        (row_o),
    .region_hit_o (region_hit_o),
    .last_o       (last_o)
  );

endmodule

>>> hw/rtl/lrc_checker.sv
// Port-level checks of the LED region compositor, bound to the top level.
// Depends on lrc_pkg and the assertion macro header.
`include "led_region_compositor_serializer_top_defines.svh"

module lrc_checker import lrc_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] status_o,
  input logic       bit_value_o,
  input logic [7:0] high_time_o,
  input logic [7:0] low_time_o,
  input logic [3:0] row_o,
  input logic       region_hit_o,
  input logic       last_o
);

  // A stalled result keeps its payload.
  `LRC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(status_o) && $stable(bit_value_o) && $stable(last_o),
    "stalled result changed")

  // Add and clear answers are single results with all symbol fields clear.
  `LRC_ASSERT_NOW(a_simple_fields, out_valid_o && status_o != STAT_SYMBOL,
    last_o && !bit_value_o && high_time_o == 8'd0 && low_time_o == 8'd0 &&
    row_o == 4'd0 && !region_hit_o,
    "simple answer carries symbol fields")

  // A query without a matching region sends only zero bits.
  `LRC_ASSERT_NOW(a_miss_zero,
    out_valid_o && status_o == STAT_SYMBOL && !region_hit_o,
    !bit_value_o, "miss symbol carries a one bit")

  // Within a query, symbols keep the same row and hit flag until the last one.
  `LRC_ASSERT_NEXT(a_sym_steady,
    out_valid_o && out_ready_i && status_o == STAT_SYMBOL && !last_o,
    out_valid_o && status_o == STAT_SYMBOL && $stable(row_o) && $stable(region_hit_o),
    "symbol stream broken before its last symbol")

endmodule

bind led_region_compositor_serializer_top lrc_checker u_lrc_checker (.*);
